[rtl/gvc_pkg.sv]
// gvc_pkg: shared widths for the greedy vertex cover core.
// No dependencies; imported by greedy_vertex_cover_core.
`timescale 1ns / 1ps

package gvc_pkg;

    localparam int INDEX_W  = 5;
    localparam int ROW_W    = 32;
    localparam int VERTEX_W = 6;

    typedef logic [VERTEX_W-1:0] t_vertex;

endpackage

[rtl/gvc_ram.sv]
// gvc_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies; used for the adjacency rows and the cover list.
`timescale 1ns / 1ps

module gvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/greedy_vertex_cover_core.sv]
// greedy_vertex_cover_core: loads adjacency rows and emits a greedy vertex cover.
// Depends on gvc_pkg and gvc_ram.
//
// Usage:
//   Input: a row beat is taken at a clock edge with start high and busy low.
//   Each beat writes one adjacency row; a beat with i_last_row set also fixes
//   the vertex count (row index + 1) and starts the cover computation.
//   Plain rows do not raise busy.
//   Output: each cover vertex (1-based) appears for one cycle with
//   o_result_stb high; the last beat carries o_last_in_cover and
//   o_cover_size. An edgeless graph gives one beat of zeros. Results cannot
//   be held off; busy drops in the cycle the last beat is on the ports.
//   After the last row the core makes the matrix symmetric, masked to the
//   vertex count; each pass then takes the neighbour of every degree-one
//   vertex and strips its edges, a max-degree scan takes a vertex when a
//   pass finds none, and the cover vertices are emitted one per beat.
//   Every step goes through the single read port of the adjacency RAM,
//   which sets the rate.
//   Reset: a clearing pass over all MAX_VERTICES rows zeroes the adjacency RAM;
//   busy is high during it.

`timescale 1ns / 1ps

module greedy_vertex_cover_core #(
    parameter int MAX_VERTICES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gvc_pkg::INDEX_W-1:0]   i_row_index,
    input  logic [gvc_pkg::ROW_W-1:0]     i_row_bits,
    input  logic                          i_last_row,
    output logic                          o_result_stb,
    output logic [gvc_pkg::VERTEX_W-1:0]  o_cover_vertex,
    output logic                          o_last_in_cover,
    output logic [gvc_pkg::VERTEX_W-1:0]  o_cover_size
);

    import gvc_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

    typedef logic [MAX_VERTICES-1:0] t_row;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE,
        S_SYM_RD, S_SYM_WR, S_SET_RD, S_SET_WR,
        S_P_RD, S_P_CHK,
        S_M_RD, S_M_CHK,
        S_ST_RD, S_ST_ROW, S_ST_NB_RD, S_ST_NB_WR,
        S_OUT
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_i, r_v, r_j, r_bi, r_optr;
    logic [CW-1:0] r_n, r_best, r_cnt;
    t_row          r_bits;
    logic          r_found, r_ret_max;
    logic          r_emit_vld, r_emit_last, r_emit_zero;

    logic          adj_we;
    logic [AW-1:0] adj_waddr, adj_raddr;
    t_row          adj_wdata, adj_rdata;
    logic          cov_we;
    logic [AW-1:0] cov_waddr, cov_raddr, cov_rdata;

    t_row          w_mask, w_sym;
    logic [AW-1:0] w_enc_rd, w_enc_bits, w_bi_new;
    logic [CW-1:0] w_pop, w_best_new;
    logic          w_one, w_accept, w_idx_ok, w_last_i;
    logic [CW-1:0] w_n_new;

    gvc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    gvc_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_cov_ram (
        .i_clk   (i_clk),
        .i_we    (cov_we),
        .i_waddr (cov_waddr),
        .i_wdata (r_state == S_P_CHK ? w_enc_rd : w_bi_new),
        .i_raddr (cov_raddr),
        .o_rdata (cov_rdata)
    );

    assign w_accept = start && !busy;
    assign w_idx_ok = 32'(i_row_index) < 32'(MAX_VERTICES);
    assign w_last_i = r_i == LAST_IDX;
    assign w_n_new  = (32'(i_row_index) + 1 > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                                 : CW'(i_row_index) + CW'(1);

    always_comb begin
        w_enc_rd   = '0;
        w_enc_bits = '0;
        w_pop      = '0;
        for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
            if (adj_rdata[k]) begin
                w_enc_rd = AW'(k);
            end
            if (r_bits[k]) begin
                w_enc_bits = AW'(k);
            end
        end
        for (int k = 0; k < MAX_VERTICES; k++) begin
            w_pop = w_pop + CW'(adj_rdata[k]);
            w_mask[k] = 32'(k) < 32'(r_n);
        end
    end

    assign w_one      = (adj_rdata != '0) && ((adj_rdata & (adj_rdata - t_row'(1))) == '0);
    assign w_sym      = (32'(r_i) < 32'(r_n)) ? (adj_rdata & w_mask & ~(t_row'(1) << r_i)) : '0;
    assign w_best_new = (w_pop > r_best) ? w_pop : r_best;
    assign w_bi_new   = (w_pop > r_best) ? r_i : r_bi;

    always_comb begin
        adj_we    = 1'b0;
        adj_waddr = r_i;
        adj_wdata = '0;
        adj_raddr = r_i;
        cov_we    = 1'b0;
        cov_waddr = AW'(r_cnt);
        cov_raddr = r_optr;
        case (r_state)
            S_CLR: begin
                adj_we = 1'b1;
            end
            S_IDLE: begin
                adj_we    = w_accept && w_idx_ok;
                adj_waddr = AW'(i_row_index);
                adj_wdata = t_row'(i_row_bits);
            end
            S_SYM_WR: begin
                adj_we    = 1'b1;
                adj_wdata = w_sym;
            end
            S_SET_RD: begin
                adj_raddr = w_enc_bits;
            end
            S_SET_WR: begin
                adj_we    = 1'b1;
                adj_waddr = r_j;
                adj_wdata = adj_rdata | (t_row'(1) << r_i);
            end
            S_P_CHK: begin
                cov_we = w_one && (32'(r_cnt) < 32'(MAX_VERTICES));
            end
            S_M_CHK: begin
                cov_we = w_last_i && (w_best_new != '0)
                         && (32'(r_cnt) < 32'(MAX_VERTICES));
            end
            S_ST_RD: begin
                adj_raddr = r_v;
            end
            S_ST_ROW: begin
                adj_we    = 1'b1;
                adj_waddr = r_v;
            end
            S_ST_NB_RD: begin
                adj_raddr = w_enc_bits;
            end
            S_ST_NB_WR: begin
                adj_we    = 1'b1;
                adj_waddr = r_j;
                adj_wdata = adj_rdata & ~(t_row'(1) << r_v);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_i         <= '0;
            r_n         <= '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_ret_max   <= 1'b0;
            r_emit_vld  <= 1'b0;
            r_emit_last <= 1'b0;
            r_emit_zero <= 1'b0;
        end else begin
            r_emit_vld <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_i <= r_i + AW'(1);
                    if (w_last_i) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept && i_last_row) begin
                        r_n     <= w_n_new;
                        r_i     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SYM_RD;
                    end
                end
                S_SYM_RD: begin
                    r_state <= S_SYM_WR;
                end
                S_SYM_WR: begin
                    r_bits  <= w_sym;
                    r_state <= S_SET_RD;
                end
                S_SET_RD: begin
                    if (r_bits == '0) begin
                        r_i <= w_last_i ? '0 : r_i + AW'(1);
                        r_found <= 1'b0;
                        r_state <= w_last_i ? S_P_RD : S_SYM_RD;
                    end else begin
                        r_j     <= w_enc_bits;
                        r_bits  <= r_bits & ~(t_row'(1) << w_enc_bits);
                        r_state <= S_SET_WR;
                    end
                end
                S_SET_WR: begin
                    r_state <= S_SET_RD;
                end
                S_P_RD: begin
                    r_state <= S_P_CHK;
                end
                S_P_CHK: begin
                    if (w_one) begin
                        if (32'(r_cnt) < 32'(MAX_VERTICES)) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        r_found   <= 1'b1;
                        r_v       <= w_enc_rd;
                        r_ret_max <= 1'b0;
                        r_state   <= S_ST_RD;
                    end else if (!w_last_i) begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_P_RD;
                    end else if (r_found) begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_state <= S_P_RD;
                    end else begin
                        r_i     <= '0;
                        r_best  <= '0;
                        r_bi    <= '0;
                        r_state <= S_M_RD;
                    end
                end
                S_M_RD: begin
                    r_state <= S_M_CHK;
                end
                S_M_CHK: begin
                    r_best <= w_best_new;
                    r_bi   <= w_bi_new;
                    if (!w_last_i) begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_M_RD;
                    end else if (w_best_new != '0) begin
                        if (32'(r_cnt) < 32'(MAX_VERTICES)) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        r_v       <= w_bi_new;
                        r_ret_max <= 1'b1;
                        r_state   <= S_ST_RD;
                    end else if (r_cnt == '0) begin
                        r_emit_vld  <= 1'b1;
                        r_emit_last <= 1'b0;
                        r_emit_zero <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_optr  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_ST_RD: begin
                    r_state <= S_ST_ROW;
                end
                S_ST_ROW: begin
                    r_bits  <= adj_rdata;
                    r_state <= S_ST_NB_RD;
                end
                S_ST_NB_RD: begin
                    if (r_bits != '0) begin
                        r_j     <= w_enc_bits;
                        r_bits  <= r_bits & ~(t_row'(1) << w_enc_bits);
                        r_state <= S_ST_NB_WR;
                    end else if (r_ret_max || w_last_i) begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_state <= S_P_RD;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_P_RD;
                    end
                end
                S_ST_NB_WR: begin
                    r_state <= S_ST_NB_RD;
                end
                S_OUT: begin
                    r_emit_vld  <= 1'b1;
                    r_emit_zero <= 1'b0;
                    r_emit_last <= (CW'(r_optr) + CW'(1)) == r_cnt;
                    r_optr      <= r_optr + AW'(1);
                    if ((CW'(r_optr) + CW'(1)) == r_cnt) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = r_state != S_IDLE;
    assign o_result_stb    = r_emit_vld;
    assign o_cover_vertex  = r_emit_zero ? '0 : VERTEX_W'(cov_rdata) + VERTEX_W'(1);
    assign o_last_in_cover = r_emit_last;
    assign o_cover_size    = r_emit_last ? VERTEX_W'(r_cnt) : '0;

endmodule

[dv/testbench.sv]
// testbench: self-checking bench for greedy_vertex_cover_core.
// Drives adjacency row beats, predicts each graph's cover, checks every result beat.
// Depends on the greedy_vertex_cover_core RTL.
`timescale 1ns / 1ps

class cover_scoreboard;
    logic [5:0] cover_q[$];
    logic       final_q[$];
    logic [5:0] size_q[$];
    logic [31:0] rows[32];
    int errors;

    function new();
        for (int i = 0; i < 32; i++) rows[i] = '0;
        errors = 0;
    endfunction

    function int pending();
        return cover_q.size();
    endfunction

    function void note_row(logic [4:0] idx, logic [31:0] bits, logic last);
        logic [31:0] sym[32];
        int deg[32];
        int taken[$];
        int n, edges, best;
        bit found;
        rows[idx] = bits;
        if (!last) return;
        n = idx + 1;
        for (int i = 0; i < 32; i++) begin
            sym[i] = '0;
        end
        for (int i = 0; i < n; i++)
            for (int k = 0; k < n; k++)
                if (k != i && rows[i][k]) begin
                    sym[i][k] = 1'b1;
                    sym[k][i] = 1'b1;
                end
        edges = 0;
        for (int i = 0; i < 32; i++) begin
            deg[i] = $countones(sym[i]);
            edges += deg[i];
            rows[i] = '0;
        end
        edges = edges / 2;
        while (edges != 0) begin
            do begin
                found = 0;
                for (int i = 0; i < 32; i++)
                    if (deg[i] == 1) begin
                        found = 1;
                        for (int k = 0; k < 32; k++)
                            if (sym[i][k]) begin
                                taken.push_back(k);
                                strip(sym, deg, edges, k);
                            end
                    end
            end while (found);
            if (edges == 0) break;
            best = 0;
            for (int i = 1; i < 32; i++)
                if (deg[i] > deg[best]) best = i;
            taken.push_back(best);
            strip(sym, deg, edges, best);
        end
        if (taken.size() == 0) begin
            cover_q.push_back(6'd0); final_q.push_back(1'b0); size_q.push_back(6'd0);
        end
        foreach (taken[j]) begin
            cover_q.push_back(6'(taken[j] + 1));
            final_q.push_back(j == taken.size() - 1);
            size_q.push_back(j == taken.size() - 1 ? 6'(taken.size()) : 6'd0);
        end
    endfunction

    function void strip(ref logic [31:0] sym[32], ref int deg[32], ref int edges, input int v);
        for (int k = 0; k < 32; k++)
            if (sym[v][k]) begin
                sym[v][k] = 1'b0;
                sym[k][v] = 1'b0;
                deg[v]--;
                deg[k]--;
                edges--;
            end
    endfunction

    function void check_result(logic [5:0] vtx, logic fin, logic [5:0] sz);
        logic [5:0] ev, es;
        logic ef;
        if (cover_q.size() == 0) begin
            $display("%0t: unexpected beat vertex=%0d last=%0d size=%0d", $time, vtx, fin, sz);
            errors++;
            return;
        end
        ev = cover_q.pop_front();
        ef = final_q.pop_front();
        es = size_q.pop_front();
        if (vtx !== ev) begin
            $display("%0t: cover_vertex expected %0d actual %0d", $time, ev, vtx);
            errors++;
        end
        if (fin !== ef) begin
            $display("%0t: last_in_cover expected %0d actual %0d", $time, ef, fin);
            errors++;
        end
        if (sz !== es) begin
            $display("%0t: cover_size expected %0d actual %0d", $time, es, sz);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [4:0]  i_row_index = '0;
    logic [31:0] i_row_bits = '0;
    logic        i_last_row = 1'b0;
    logic        o_result_stb;
    logic [5:0]  o_cover_vertex;
    logic        o_last_in_cover;
    logic [5:0]  o_cover_size;

    cover_scoreboard sb = new();
    int idle_cycles = 0;
    int sent_rows = 0;
    bit calm = 0;

    always #10 i_clk = ~i_clk;

    greedy_vertex_cover_core #(.MAX_VERTICES(32)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_row_index(i_row_index), .i_row_bits(i_row_bits), .i_last_row(i_last_row),
        .o_result_stb(o_result_stb), .o_cover_vertex(o_cover_vertex),
        .o_last_in_cover(o_last_in_cover), .o_cover_size(o_cover_size)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_stb) sb.check_result(o_cover_vertex, o_last_in_cover, o_cover_size);
        if (!i_rst_n || o_result_stb || (start && !busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 200000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_row(logic [4:0] idx, logic [31:0] bits, logic last);
        while (!calm && $urandom_range(99) < 12) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_row_index <= idx;
        i_row_bits <= bits;
        i_last_row <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_row(idx, bits, last);
        sent_rows++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_bits(int density);
        logic [31:0] b = '0;
        for (int k = 0; k < 32; k++) b[k] = ($urandom_range(99) < density);
        return b;
    endfunction

    task automatic send_graph(int n, int density);
        int rows = $urandom_range(n - 1, 0);
        for (int r = 0; r < rows; r++)
            send_row(5'($urandom_range(n - 1, 0)), rand_bits(density), 1'b0);
        send_row(5'(n - 1), rand_bits(density), 1'b1);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_row(5'd0, 32'h0, 1'b1);
        send_row(5'd31, 32'h0, 1'b1);
        send_row(5'd31, 32'hFFFF_FFFF, 1'b1);
        send_row(5'd0, 32'h0000_0002, 1'b0);
        send_row(5'd1, 32'h0000_0003, 1'b1);
        send_row(5'd4, 32'hFFFF_FFE0, 1'b1);
        send_row(5'd0, 32'hFFFF_FFFF, 1'b0);
        send_row(5'd5, 32'h0000_0001, 1'b0);
        send_row(5'd5, 32'h0000_0004, 1'b0);
        send_row(5'd2, 32'h0000_0008, 1'b0);
        send_row(5'd7, 32'h0000_0001, 1'b1);
        for (int i = 0; i < 8; i++) send_row(5'(i), 32'h1 << (i + 1), i == 7);
        send_row(5'd3, 32'h0000_000F, 1'b1);
        send_row(5'd31, 32'hAAAA_5555, 1'b1);
        while (sent_rows < 410) begin
            int n;
            calm = (sent_rows > 150 && sent_rows < 230);
            n = ($urandom_range(9) == 0) ? 32 : $urandom_range(12, 1);
            if ($urandom_range(9) == 0) begin
                send_row(5'($urandom_range(31)), $urandom, 1'($urandom_range(1)));
            end else begin
                send_graph(n, $urandom_range(60, 5));
            end
        end
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/gvc_pkg.sv
rtl/gvc_ram.sv
rtl/greedy_vertex_cover_core.sv
dv/testbench.sv
